>>> hw/rtl/fls_pkg.sv
// Shared types and constants for the free list slot allocator.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package fls_pkg;

  localparam int DEFAULT_MAX_SLOTS = 256;

  localparam int SLOT_COUNT_W  = 9;
  localparam int SLOT_BYTES_W  = 13;
  localparam int SLOT_W        = 8;
  localparam int OFFSET_W      = 20;
  localparam int USED_W        = 9;
  localparam int FREE_BYTES_W  = 21;
  localparam int CFG_INDEX_W   = 1;
  localparam int CFG_DATA_W    = 13;

  localparam logic [SLOT_COUNT_W-1:0] SLOT_COUNT_RESET = 9'd256;
  localparam logic [SLOT_BYTES_W-1:0] SLOT_BYTES_RESET = 13'd16;

  localparam logic [CFG_INDEX_W-1:0] REG_SLOT_COUNT = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_SLOT_BYTES = 1'b1;

  typedef enum logic [0:0] {
    ACT_ALLOC = 1'b0,
    ACT_FREE  = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_FULL    = 2'd1,
    ST_IGNORED = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CS_SWEEP,
    CS_IDLE,
    CS_EXEC,
    CS_HOLD
  } ctrl_state_t;

  typedef struct packed {
    logic sweep_start;
    logic sweep;
    logic accept;
    logic exec;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic rebuild;
    logic sweep_last;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

>>> hw/rtl/fls_if.sv
// Request and response channel interfaces of the free list slot allocator.
// Depends on fls_pkg for field widths and codes.
`timescale 1ns / 1ps
`default_nettype none

interface fls_req_if import fls_pkg::*; ();
  logic              valid;
  logic              ready;
  action_t           action;
  logic [SLOT_W-1:0] slot_in;

  modport source (output valid, output action, output slot_in, input ready);
  modport sink (input valid, input action, input slot_in, output ready);
endinterface

interface fls_rsp_if import fls_pkg::*; ();
  logic                    valid;
  logic                    ready;
  status_t                 status;
  logic [SLOT_W-1:0]       slot_out;
  logic [OFFSET_W-1:0]     byte_offset;
  logic [USED_W-1:0]       used_now;
  logic [FREE_BYTES_W-1:0] free_bytes;

  modport source (output valid, output status, output slot_out, output byte_offset,
                  output used_now, output free_bytes, input ready);
  modport sink (input valid, input status, input slot_out, input byte_offset,
                input used_now, input free_bytes, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/fls_ctrl.sv
// Sequencer of the free list slot allocator: rebuild sweep, request and output load.
// Depends on fls_pkg; drives the datapath through dp_cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module fls_ctrl import fls_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire dp_status_t status,
  output dp_cmd_t         cmd
);

  ctrl_state_t state;
  ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CS_SWEEP;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      CS_SWEEP: begin
        if (status.rebuild) begin
          cmd.sweep_start = 1'b1;
        end else begin
          cmd.sweep = 1'b1;
          if (status.sweep_last) begin
            state_next = CS_IDLE;
          end
        end
      end
      CS_IDLE: begin
        in_ready = !status.rebuild;
        if (status.rebuild) begin
          cmd.sweep_start = 1'b1;
          state_next      = CS_SWEEP;
        end else if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = CS_EXEC;
        end
      end
      CS_EXEC: begin
        cmd.exec = 1'b1;
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = CS_IDLE;
        end else begin
          state_next = CS_HOLD;
        end
      end
      CS_HOLD: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = CS_IDLE;
        end
      end
      default: begin
        state_next = CS_SWEEP;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> hw/rtl/fls_datapath.sv
// Datapath of the free list slot allocator: link memory, head, counts and result register.
// Depends on fls_pkg; commanded by fls_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module fls_datapath import fls_pkg::*; #(
  parameter int MAX_SLOTS = DEFAULT_MAX_SLOTS
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire dp_cmd_t                  cmd,
  output dp_status_t                    status,
  input  wire logic                     cfg_we,
  input  wire logic [CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]    cfg_data,
  input  wire action_t                  action,
  input  wire logic [SLOT_W-1:0]        slot_in,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output status_t                       out_status,
  output logic [SLOT_W-1:0]             out_slot,
  output logic [OFFSET_W-1:0]           out_offset,
  output logic [USED_W-1:0]             out_used,
  output logic [FREE_BYTES_W-1:0]       out_free_bytes
);

  localparam int IW  = $clog2(MAX_SLOTS);
  localparam int LW  = $clog2(MAX_SLOTS + 1);
  localparam int CAP = (MAX_SLOTS > 511) ? 511 : MAX_SLOTS;
  localparam logic [SLOT_COUNT_W-1:0] COUNT_CAP = SLOT_COUNT_W'(CAP);
  localparam logic [LW-1:0] LINK_END = LW'(MAX_SLOTS);
  localparam logic [IW-1:0] SWEEP_LAST = IW'(MAX_SLOTS - 1);

  typedef logic [IW-1:0] idx_tbl_t [256];

  // Reduction of an 8-bit slot index into the pool, built by counting.
  function automatic idx_tbl_t build_mod_table();
    idx_tbl_t tbl;
    int       r;
    r = 0;
    for (int i = 0; i < 256; i++) begin
      tbl[i] = IW'(r);
      r = (r == MAX_SLOTS - 1) ? 0 : r + 1;
    end
    return tbl;
  endfunction

  localparam idx_tbl_t MOD_TBL = build_mod_table();

  logic [LW-1:0] link_mem [MAX_SLOTS];

  logic [SLOT_COUNT_W-1:0] slot_count;
  logic [SLOT_BYTES_W-1:0] slot_bytes;
  logic [LW-1:0]           head;
  logic [USED_W-1:0]       used;
  logic [IW-1:0]           sweep_cnt;
  logic [LW-1:0]           rd_data;
  status_t                 req_status;
  logic [SLOT_W-1:0]       req_slot;
  logic [USED_W-1:0]       req_used;
  logic                    req_alloc;

  logic [SLOT_COUNT_W-1:0] count;
  logic                    alloc_ok;
  logic                    free_ok;
  logic [IW-1:0]           free_idx;
  logic [USED_W-1:0]       used_next;
  status_t                 status_next;
  logic                    mem_we;
  logic [IW-1:0]           mem_waddr;
  logic [LW-1:0]           mem_wdata;
  logic [SLOT_COUNT_W-1:0] remain;

  assign count    = (slot_count > COUNT_CAP) ? COUNT_CAP : slot_count;
  assign free_idx = MOD_TBL[slot_in];
  assign alloc_ok = (action == ACT_ALLOC) && (used < count) && (head < LINK_END);
  assign free_ok  = (action == ACT_FREE) && (used != '0);

  always_comb begin
    used_next   = used;
    status_next = ST_DONE;
    if (action == ACT_ALLOC) begin
      if (alloc_ok) begin
        used_next = used + USED_W'(1);
      end else begin
        status_next = ST_FULL;
      end
    end else begin
      if (free_ok) begin
        used_next = used - USED_W'(1);
      end else begin
        status_next = ST_IGNORED;
      end
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = sweep_cnt;
    mem_wdata = LW'(sweep_cnt) + LW'(1);
    if (cmd.sweep) begin
      mem_we = 1'b1;
    end else if (cmd.accept && free_ok) begin
      mem_we    = 1'b1;
      mem_waddr = free_idx;
      mem_wdata = head;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      link_mem[mem_waddr] <= mem_wdata;
    end
    if (cmd.accept) begin
      rd_data <= link_mem[head[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_count <= SLOT_COUNT_RESET;
      slot_bytes <= SLOT_BYTES_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SLOT_COUNT: slot_count <= cfg_data[SLOT_COUNT_W-1:0];
        REG_SLOT_BYTES: slot_bytes <= cfg_data[SLOT_BYTES_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.sweep_start) begin
      sweep_cnt <= '0;
      head      <= '0;
      used      <= '0;
    end else begin
      if (cmd.sweep) begin
        sweep_cnt <= sweep_cnt + IW'(1);
      end
      if (cmd.accept) begin
        used <= used_next;
        if (free_ok) begin
          head <= LW'(free_idx);
        end
      end else if (cmd.exec && req_alloc) begin
        head <= rd_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_status <= status_next;
      req_slot   <= alloc_ok ? SLOT_W'(head) : '0;
      req_used   <= used_next;
      req_alloc  <= alloc_ok;
    end
  end

  assign remain = count - req_used;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status     <= req_status;
      out_slot       <= req_slot;
      out_used       <= req_used;
      out_offset     <= OFFSET_W'(req_slot) * OFFSET_W'(slot_bytes);
      out_free_bytes <= FREE_BYTES_W'(remain) * FREE_BYTES_W'(slot_bytes);
    end
  end

  assign status.rebuild    = cfg_we && (cfg_index == REG_SLOT_COUNT);
  assign status.sweep_last = (sweep_cnt == SWEEP_LAST);
  assign status.out_free   = !out_valid || out_ready;

endmodule

`default_nettype wire

>>> hw/rtl/free_list_slot_allocator_core.sv
// Top level of the free list slot allocator: joins controller and datapath.
// Depends on fls_pkg, fls_if, fls_ctrl and fls_datapath.
//
// The block hands out fixed-size slots from a pool kept as a linked free list.
// A request transaction on req carries action (allocate or free) and slot_in.
// Each request gives exactly one response transaction on rsp with the status,
// the allocated slot, its byte offset, the used count and the free bytes.
// The user must write registers through cfg_we, cfg_index and cfg_data while
// idle (not enforced by the block); index 0 is the slot count, index 1 the
// slot size in bytes. A request is accepted in CS_IDLE, passes CS_EXEC and
// is loaded into the output register when that is free. No new request is
// taken meanwhile, as it needs the registered read of the head's link in
// the link memory. After reset, and after a slot count write while idle or
// sweeping, the block rebuilds the list in a sweep, one link per cycle,
// during which req.ready stays low; register writes are still taken.
// A finished response is held in an output register; while it waits, one
// more request is accepted and processed, then held until rsp is taken.
`timescale 1ns / 1ps
`default_nettype none

module free_list_slot_allocator_core import fls_pkg::*; #(
  parameter int MAX_SLOTS = DEFAULT_MAX_SLOTS
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  fls_req_if.sink                     req,
  fls_rsp_if.source                   rsp,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t status;

  fls_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .status   (status),
    .cmd      (cmd)
  );

  fls_datapath #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .action         (req.action),
    .slot_in        (req.slot_in),
    .out_valid      (rsp.valid),
    .out_ready      (rsp.ready),
    .out_status     (rsp.status),
    .out_slot       (rsp.slot_out),
    .out_offset     (rsp.byte_offset),
    .out_used       (rsp.used_now),
    .out_free_bytes (rsp.free_bytes)
  );

endmodule

`default_nettype wire
